// ===== src/xcr_pkg.sv =====
package xcr_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int OFFSET_W = $clog2(BLOCK_BYTES);
  localparam logic [OFFSET_W-1:0] LAST_OFFSET = OFFSET_W'(BLOCK_BYTES - 1);

  localparam int IDLE_W = 20;
  localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};
  localparam logic [IDLE_W-1:0] NAK_INTERVAL_RESET = IDLE_W'(400000);

  // Control characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_EOF = 8'h1A;
  localparam logic [7:0] COMP_MASK = 8'hFF;

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_TX = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;

  // End status codes
  localparam logic [1:0] END_RUN = 2'd0;
  localparam logic [1:0] END_EOT = 2'd1;
  localparam logic [1:0] END_CANCEL = 2'd2;

  // Register index
  localparam logic REG_NAK_INTERVAL = 1'b0;

  typedef struct packed {
    logic                valid;
    logic [1:0]          kind;
    logic [7:0]          data;
    logic [OFFSET_W-1:0] offset;
    logic [15:0]         slot;
    logic [1:0]          end_status;
    logic [7:0]          final_block;
  } result_t;

endpackage

// ===== src/xcr_proto.sv =====
module xcr_proto (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic                     opcode,
  input  logic [7:0]               rx_byte,
  input  logic [xcr_pkg::IDLE_W-1:0] nak_interval,
  output xcr_pkg::result_t         res
);

  typedef enum logic [2:0] {
    PH_START, PH_HEADER, PH_NUM, PH_COMP, PH_DATA, PH_SUM, PH_DONE
  } phase_t;

  phase_t                        phase, phase_next;
  logic [xcr_pkg::IDLE_W-1:0]    idle_count, idle_count_next;
  logic [7:0]                    expected_block, expected_block_next;
  logic                          packet_bad, packet_bad_next;
  logic [xcr_pkg::OFFSET_W-1:0]  byte_offset, byte_offset_next;
  logic [7:0]                    running_sum, running_sum_next;
  logic [7:0]                    received_number, received_number_next;
  logic [15:0]                   accepted_blocks, accepted_blocks_next;
  logic [7:0]                    sum_add;

  assign sum_add = running_sum + rx_byte;

  always_comb begin
    phase_next = phase;
    idle_count_next = idle_count;
    expected_block_next = expected_block;
    packet_bad_next = packet_bad;
    byte_offset_next = byte_offset;
    running_sum_next = running_sum;
    received_number_next = received_number;
    accepted_blocks_next = accepted_blocks;
    res = '0;

    if (phase == PH_DONE) begin
      // drop everything until reset
    end else if (opcode == xcr_pkg::OP_POLL) begin
      if (phase == PH_START) begin
        if (idle_count > nak_interval) begin
          idle_count_next = '0;
          res.valid = 1'b1;
          res.kind = xcr_pkg::KIND_TX;
          res.data = xcr_pkg::CH_NAK;
        end else if (idle_count != xcr_pkg::IDLE_MAX) begin
          idle_count_next = idle_count + 1'b1;
        end
      end
    end else begin
      unique case (phase)
        PH_START, PH_HEADER: begin
          phase_next = PH_HEADER;
          if (rx_byte == xcr_pkg::CH_SOH) begin
            phase_next = PH_NUM;
            packet_bad_next = 1'b0;
            byte_offset_next = '0;
            running_sum_next = '0;
          end else if (rx_byte == xcr_pkg::CH_EOT) begin
            phase_next = PH_DONE;
            res.valid = 1'b1;
            res.kind = xcr_pkg::KIND_TX;
            res.data = xcr_pkg::CH_ACK;
            res.end_status = xcr_pkg::END_EOT;
            res.final_block = expected_block;
          end else if (rx_byte == xcr_pkg::CH_CAN || rx_byte == xcr_pkg::CH_EOF) begin
            phase_next = PH_DONE;
            res.valid = 1'b1;
            res.kind = xcr_pkg::KIND_CANCEL;
            res.end_status = xcr_pkg::END_CANCEL;
          end
        end
        PH_NUM: begin
          received_number_next = rx_byte;
          if (rx_byte != expected_block) packet_bad_next = 1'b1;
          phase_next = PH_COMP;
        end
        PH_COMP: begin
          if ((received_number ^ rx_byte) != xcr_pkg::COMP_MASK) packet_bad_next = 1'b1;
          phase_next = PH_DATA;
          byte_offset_next = '0;
        end
        PH_DATA: begin
          running_sum_next = sum_add;
          if (byte_offset == xcr_pkg::LAST_OFFSET) phase_next = PH_SUM;
          byte_offset_next = byte_offset + 1'b1;
          if (!packet_bad) begin
            res.valid = 1'b1;
            res.kind = xcr_pkg::KIND_DATA;
            res.data = rx_byte;
            res.offset = byte_offset;
            res.slot = accepted_blocks;
          end
        end
        PH_SUM: begin
          phase_next = PH_HEADER;
          res.valid = 1'b1;
          res.kind = xcr_pkg::KIND_TX;
          if (packet_bad || running_sum != rx_byte) begin
            packet_bad_next = 1'b1;
            res.data = xcr_pkg::CH_NAK;
          end else begin
            expected_block_next = expected_block + 1'b1;
            accepted_blocks_next = accepted_blocks + 1'b1;
            res.data = xcr_pkg::CH_ACK;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      idle_count <= '0;
      expected_block <= 8'd1;
      packet_bad <= 1'b0;
      byte_offset <= '0;
      running_sum <= '0;
      received_number <= '0;
      accepted_blocks <= '0;
    end else if (step) begin
      phase <= phase_next;
      idle_count <= idle_count_next;
      expected_block <= expected_block_next;
      packet_bad <= packet_bad_next;
      byte_offset <= byte_offset_next;
      running_sum <= running_sum_next;
      received_number <= received_number_next;
      accepted_blocks <= accepted_blocks_next;
    end
  end

`ifndef SYNTHESIS
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |=> phase == PH_DONE)
    else $error("left done phase without reset");

  a_idle_frozen: assert property (@(posedge clk) disable iff (rst)
    phase != PH_START |=> $stable(idle_count))
    else $error("idle count moved outside start phase");

  a_data_only_good: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == xcr_pkg::KIND_DATA |-> phase == PH_DATA && !packet_bad)
    else $error("data byte passed out of a bad or absent packet");
`endif

endmodule

// ===== src/xmodem_checksum_receiver_core.sv =====
// XMODEM receiver core for 128-byte blocks with an 8-bit additive checksum.
// Each input transaction is one received byte (opcode 0) or one idle poll tick
// (opcode 1) and yields at most one result: a data byte with its slot and
// offset, a reply byte to transmit (ACK/NAK), or a cancel notice. Throughput is
// one transaction per clock: the protocol state updates in a single pass at the
// accepting edge and the result lands in one output register, so a result
// appears in the cycle after its input, and a new input is taken whenever that
// register is empty or being drained in the same cycle. The start NAK interval
// is set through the APB register at address 0 and should only be changed while
// the core is idle.
module xmodem_checksum_receiver_core (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [6:0]  out_offset,
  output logic [15:0] out_slot,
  output logic [1:0]  end_status,
  output logic [7:0]  final_block
);

  logic [xcr_pkg::IDLE_W-1:0] nak_interval;
  logic                       reg_hit;
  logic                       step;
  xcr_pkg::result_t           res;

  assign pready = 1'b1;
  assign reg_hit = (paddr[1:0] == 2'b00) && (paddr[2] == xcr_pkg::REG_NAK_INTERVAL);
  assign prdata = reg_hit ? {{(32 - xcr_pkg::IDLE_W){1'b0}}, nak_interval} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      nak_interval <= xcr_pkg::NAK_INTERVAL_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      nak_interval <= pwdata[xcr_pkg::IDLE_W-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign step = in_valid && in_ready;

  xcr_proto u_proto (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .opcode       (opcode),
    .rx_byte      (rx_byte),
    .nak_interval (nak_interval),
    .res          (res)
  );

  // hold the result until taken; load a fresh one on each producing transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_kind <= res.kind;
      out_byte <= res.data;
      out_offset <= res.offset;
      out_slot <= res.slot;
      end_status <= res.end_status;
      final_block <= res.final_block;
    end
  end

endmodule
